// ----- rtl/lil_pkg.sv -----
package lil_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int INDEX_W = 12;
   localparam int COMPARE_W = 13;
   localparam int GROUP_SIZE = 8;

   localparam logic [1:0] KIND_APPEND = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_ERASE  = 2'd2;
   localparam logic [1:0] KIND_GET    = 2'd3;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_ERASE_OOR  = 2'd1;
   localparam logic [1:0] STATUS_FULL       = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [11:0]        position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [6:0]         count;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic               shift_up;
      logic               shift_down;
      logic               read_en;
      logic [INDEX_W-1:0] target;
      logic signed [31:0] value;
   } cell_ctrl_type;

endpackage

// ----- rtl/indexed_insert_erase_list.sv -----
// Indexed insert/erase list: an ordered list of signed 32-bit values held in a
// row of CAPACITY register cells, with a count of the entries held.
// An item is taken at a rising edge where start is high and busy is low. Its
// kind is append, insert at position, erase at position or get at position.
// Every item gives exactly one result on rsp_item, marked by rsp_strobe for a
// single cycle: the entry read by a get, the count after the item and a status
// (ok, erase index out of range, or store full with the value dropped).
// rsp_strobe and rsp_item are registered as the REDUCE state that follows the
// accepting edge ends. Busy is high only in REDUCE, so a new item can be taken
// while the previous result is shown on rsp_item.
// At the accepting edge all cells shift in parallel and each group of eight
// cells is reduced to one registered word; REDUCE merges the group words.
// Reset clears the count and the control state; the cell contents are not
// cleared, since only entries below the count are ever read.
// The receiver cannot stall: each result must be taken in its strobe cycle.
module indexed_insert_erase_list #(
   parameter int CAPACITY = lil_pkg::DEFAULT_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lil_pkg::req_type req_item,
   output logic             rsp_strobe,
   output lil_pkg::rsp_type rsp_item
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int NGROUPS = (CAPACITY + lil_pkg::GROUP_SIZE - 1) / lil_pkg::GROUP_SIZE;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_REDUCE = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   lil_pkg::rsp_type rsp_ff, rsp_in;
   logic signed [31:0] group_ff [NGROUPS];
   logic signed [31:0] group_in [NGROUPS];

   lil_pkg::cell_ctrl_type ctrl;
   logic signed [31:0] cell_data [CAPACITY];
   logic signed [31:0] cell_rd [CAPACITY];

   logic accept;
   logic [lil_pkg::COMPARE_W-1:0] pos_ext;
   logic [lil_pkg::COMPARE_W-1:0] count_ext;
   logic in_range;
   logic full;
   logic [1:0] status_new;
   logic signed [31:0] merged;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign pos_ext   = lil_pkg::COMPARE_W'(req_item.position);
   assign count_ext = lil_pkg::COMPARE_W'(count_ff);
   assign in_range  = pos_ext < count_ext;
   assign full      = count_ext >= lil_pkg::COMPARE_W'(CAPACITY);

   always_comb begin
      ctrl            = '0;
      ctrl.value      = req_item.value;
      ctrl.target     = req_item.position;
      count_in        = count_ff;
      status_new      = lil_pkg::STATUS_OK;
      unique case (req_item.kind)
         lil_pkg::KIND_APPEND, lil_pkg::KIND_INSERT: begin
            if (full) begin
               status_new = lil_pkg::STATUS_FULL;
            end else begin
               ctrl.shift_up = accept;
               if (req_item.kind == lil_pkg::KIND_APPEND || !in_range) begin
                  ctrl.target = lil_pkg::INDEX_W'(count_ff);
               end
               if (accept) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         lil_pkg::KIND_ERASE: begin
            if (!in_range) begin
               status_new = lil_pkg::STATUS_ERASE_OOR;
            end else begin
               ctrl.shift_down = accept;
               if (accept) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         lil_pkg::KIND_GET: begin
            ctrl.read_en = accept && in_range;
         end
         default: begin
            status_new = lil_pkg::STATUS_OK;
         end
      endcase
   end

   genvar c;
   generate
      for (c = 0; c < CAPACITY; c++) begin : g_cell
         logic signed [31:0] left_d;
         logic signed [31:0] right_d;
         if (c == 0) begin : g_first
            assign left_d = 32'sd0;
         end else begin : g_inner_l
            assign left_d = cell_data[c-1];
         end
         if (c == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[c];
         end else begin : g_inner_r
            assign right_d = cell_data[c+1];
         end
         lil_cell #(
            .INDEX(c)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[c]),
            .rd_data    (cell_rd[c])
         );
      end
   endgenerate

   always_comb begin
      for (int g = 0; g < NGROUPS; g++) begin
         group_in[g] = 32'sd0;
         for (int j = 0; j < lil_pkg::GROUP_SIZE; j++) begin
            if (g * lil_pkg::GROUP_SIZE + j < CAPACITY) begin
               group_in[g] = group_in[g] | cell_rd[g * lil_pkg::GROUP_SIZE + j];
            end
         end
      end
      merged = 32'sd0;
      for (int g = 0; g < NGROUPS; g++) begin
         merged = merged | group_ff[g];
      end
   end

   always_comb begin
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in      = ST_REDUCE;
               rsp_in.count  = 7'(count_in);
               rsp_in.status = status_new;
            end
         end
         ST_REDUCE: begin
            state_in          = ST_IDLE;
            rsp_strobe_in     = 1'b1;
            rsp_in.read_value = merged;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      for (int g = 0; g < NGROUPS; g++) begin
         group_ff[g] <= group_in[g];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted item");

   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("result missing two cycles after accept");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ext <= lil_pkg::COMPARE_W'(CAPACITY))
      else $error("count exceeds capacity");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && !$past(rsp_strobe))
      else $error("result strobe outside its single cycle");

endmodule

// ----- rtl/lil_cell.sv -----
module lil_cell #(
   parameter int INDEX = 0
) (
   input  logic                       clock,
   input  lil_pkg::cell_ctrl_type     ctrl,
   input  logic signed [31:0]         left_data,
   input  logic signed [31:0]         right_data,
   output logic signed [31:0]         data,
   output logic signed [31:0]         rd_data
);

   localparam logic [lil_pkg::INDEX_W-1:0] MY_INDEX = lil_pkg::INDEX_W'(INDEX);

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.shift_up) begin
         if (MY_INDEX == ctrl.target) begin
            data_in = ctrl.value;
         end else if (MY_INDEX > ctrl.target) begin
            data_in = left_data;
         end
      end else if (ctrl.shift_down) begin
         if (MY_INDEX >= ctrl.target) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign rd_data = (ctrl.read_en && MY_INDEX == ctrl.target) ? data_ff : 32'sd0;

endmodule
